[design/ps2mc_pkg.sv]
`timescale 1ns / 1ps

package ps2mc_pkg;

	// Defaults for the top level's parameter and the reset register values
	localparam int COORD_BITS_DEF   = 12;
	localparam int SCREEN_WIDTH_DEF  = 640;
	localparam int SCREEN_HEIGHT_DEF = 480;

	// Register map, word index taken from paddr[3:2]
	localparam int PADDR_BITS = 4;
	typedef enum logic [1:0] {
		REG_SCREEN_WIDTH  = 2'd0,
		REG_SCREEN_HEIGHT = 2'd1,
		REG_WHEEL_MODE    = 2'd2
	} reg_idx_t;

	// Flag byte layout
	localparam int FLAG_LEFT   = 0;
	localparam int FLAG_RIGHT  = 1;
	localparam int FLAG_MIDDLE = 2;
	localparam int FLAG_XSIGN  = 4;
	localparam int FLAG_YSIGN  = 5;

	// Wheel byte codes
	localparam logic [7:0] WHEEL_DOWN_BYTE = 8'h01;
	localparam logic [7:0] WHEEL_UP_BYTE   = 8'hFF;

	typedef enum logic [1:0] {
		WHEEL_NONE = 2'd0,
		WHEEL_DOWN = 2'd1,
		WHEEL_UP   = 2'd2
	} wheel_t;

	// Byte slots within a packet
	typedef enum logic [1:0] {
		SLOT_FLAGS = 2'd0,
		SLOT_DX    = 2'd1,
		SLOT_DY    = 2'd2,
		SLOT_WHEEL = 2'd3
	} slot_t;

	// Register write strobes, one per register
	typedef struct packed {
		logic width;
		logic height;
		logic mode;
	} cfg_wr_t;

	// A complete packet as handed to the cursor logic
	typedef struct packed {
		logic [7:0] flags;
		logic [7:0] dx;
		logic [7:0] dy;
		wheel_t     wheel;
	} pkt_t;

endpackage

[design/ps2mc_apb_regs.sv]
`timescale 1ns / 1ps

module ps2mc_apb_regs
	import ps2mc_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [PADDR_BITS-1:0]   paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output cfg_wr_t                 cfg_wr,
	output logic [COORD_BITS:0]     cfg_wdata,
	output logic [COORD_BITS:0]     screen_width_q,
	output logic [COORD_BITS:0]     screen_height_q,
	output logic                    wheel_mode_q
);

	// Reset sizes saturate at the coordinate range
	localparam int LIMIT = 2 ** COORD_BITS;
	localparam int RST_W = (SCREEN_WIDTH_DEF > LIMIT) ? LIMIT : SCREEN_WIDTH_DEF;
	localparam int RST_H = (SCREEN_HEIGHT_DEF > LIMIT) ? LIMIT : SCREEN_HEIGHT_DEF;

	logic     wr_en;
	reg_idx_t idx;

	assign wr_en     = psel && penable && pwrite;
	assign idx       = reg_idx_t'(paddr[PADDR_BITS-1:2]);
	assign cfg_wdata = pwdata[COORD_BITS:0];

	always_comb begin
		cfg_wr = '0;
		case (idx)
			REG_SCREEN_WIDTH:  cfg_wr.width  = wr_en;
			REG_SCREEN_HEIGHT: cfg_wr.height = wr_en;
			REG_WHEEL_MODE:    cfg_wr.mode   = wr_en;
			default:           cfg_wr        = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= (COORD_BITS+1)'(RST_W);
			screen_height_q <= (COORD_BITS+1)'(RST_H);
			wheel_mode_q    <= 1'b0;
		end else begin
			if (cfg_wr.width)
				screen_width_q <= cfg_wdata;
			if (cfg_wr.height)
				screen_height_q <= cfg_wdata;
			if (cfg_wr.mode)
				wheel_mode_q <= pwdata[0];
		end
	end

	always_comb begin
		case (idx)
			REG_SCREEN_WIDTH:  prdata = 32'(screen_width_q);
			REG_SCREEN_HEIGHT: prdata = 32'(screen_height_q);
			REG_WHEEL_MODE:    prdata = 32'(wheel_mode_q);
			default:           prdata = '0;
		endcase
	end

endmodule

[design/ps2mc_packet_asm.sv]
`timescale 1ns / 1ps

module ps2mc_packet_asm
	import ps2mc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_wr_t    cfg_wr,
	input  logic       wheel_mode,
	input  logic       byte_en,
	input  logic [7:0] rx_byte,
	output logic       pkt_done,
	output pkt_t       pkt
);

	slot_t      slot_q;
	slot_t      last_slot;
	logic [7:0] flags_q;
	logic [7:0] dx_q;
	logic [7:0] dy_q;

	// Framing is by count only; the always-one flag bit is not checked
	assign last_slot = wheel_mode ? SLOT_WHEEL : SLOT_DY;
	assign pkt_done  = (slot_q == last_slot);

	always_comb begin
		pkt.flags = flags_q;
		pkt.dx    = dx_q;
		pkt.dy    = wheel_mode ? dy_q : rx_byte;
		pkt.wheel = WHEEL_NONE;
		if (wheel_mode) begin
			if (rx_byte == WHEEL_DOWN_BYTE)
				pkt.wheel = WHEEL_DOWN;
			else if (rx_byte == WHEEL_UP_BYTE)
				pkt.wheel = WHEEL_UP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= SLOT_FLAGS;
			flags_q <= '0;
			dx_q    <= '0;
			dy_q    <= '0;
		end else if (cfg_wr.mode) begin
			slot_q <= SLOT_FLAGS;
		end else if (byte_en) begin
			if (pkt_done) begin
				slot_q <= SLOT_FLAGS;
				dy_q   <= pkt.dy;
			end else begin
				slot_q <= slot_t'(slot_q + 2'd1);
				case (slot_q)
					SLOT_FLAGS: flags_q <= rx_byte;
					SLOT_DX:    dx_q    <= rx_byte;
					SLOT_DY:    dy_q    <= rx_byte;
					default:    dy_q    <= dy_q;
				endcase
			end
		end
	end

endmodule

[design/ps2mc_cursor.sv]
`timescale 1ns / 1ps

module ps2mc_cursor
	import ps2mc_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_wr_t               cfg_wr,
	input  logic [COORD_BITS:0]   cfg_wdata,
	input  logic [COORD_BITS:0]   screen_width,
	input  logic [COORD_BITS:0]   screen_height,
	input  logic                  pkt_en,
	input  pkt_t                  pkt,
	output logic [COORD_BITS-1:0] next_x,
	output logic [COORD_BITS-1:0] next_y,
	output logic [COORD_BITS-1:0] x_top,
	output logic [COORD_BITS-1:0] y_top
);

	localparam int SW = COORD_BITS + 2;
	localparam int LIMIT = 2 ** COORD_BITS;
	localparam int RST_W = (SCREEN_WIDTH_DEF > LIMIT) ? LIMIT : SCREEN_WIDTH_DEF;
	localparam int RST_H = (SCREEN_HEIGHT_DEF > LIMIT) ? LIMIT : SCREEN_HEIGHT_DEF;
	localparam logic [COORD_BITS:0] LIMIT_V = {1'b1, {COORD_BITS{1'b0}}};

	// Size 0 acts as 1, anything past the coordinate range as the full range
	function automatic logic [COORD_BITS:0] eff_size(input logic [COORD_BITS:0] s);
		logic [COORD_BITS:0] r;
		if (s == '0)
			r = (COORD_BITS+1)'(1);
		else if (s > LIMIT_V)
			r = LIMIT_V;
		else
			r = s;
		return r;
	endfunction

	function automatic logic [COORD_BITS-1:0] clamp(input logic signed [SW-1:0] v,
			input logic [COORD_BITS-1:0] top);
		logic [COORD_BITS-1:0] r;
		if (v < 0)
			r = '0;
		else if (v > $signed({2'b00, top}))
			r = top;
		else
			r = v[COORD_BITS-1:0];
		return r;
	endfunction

	logic [COORD_BITS-1:0]   pos_x_q;
	logic [COORD_BITS-1:0]   pos_y_q;
	logic [COORD_BITS:0]     eff_w;
	logic [COORD_BITS:0]     eff_h;
	logic [COORD_BITS:0]     eff_new;
	logic [COORD_BITS-1:0]   center_new;
	logic signed [SW-1:0]    dx_ext;
	logic signed [SW-1:0]    dy_ext;
	logic signed [SW-1:0]    sum_x;
	logic signed [SW-1:0]    sum_y;

	assign eff_w      = eff_size(screen_width);
	assign eff_h      = eff_size(screen_height);
	assign x_top      = COORD_BITS'(eff_w - (COORD_BITS+1)'(1));
	assign y_top      = COORD_BITS'(eff_h - (COORD_BITS+1)'(1));
	assign eff_new    = eff_size(cfg_wdata);
	assign center_new = eff_new[COORD_BITS:1];

	// Nine-bit deltas with the sign taken from the flag byte
	assign dx_ext = {{(SW-8){pkt.flags[FLAG_XSIGN]}}, pkt.dx};
	assign dy_ext = {{(SW-8){pkt.flags[FLAG_YSIGN]}}, pkt.dy};
	assign sum_x  = $signed({2'b00, pos_x_q}) + dx_ext;
	assign sum_y  = $signed({2'b00, pos_y_q}) - dy_ext;
	assign next_x = clamp(sum_x, x_top);
	assign next_y = clamp(sum_y, y_top);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= COORD_BITS'(RST_W / 2);
			pos_y_q <= COORD_BITS'(RST_H / 2);
		end else begin
			if (cfg_wr.width)
				pos_x_q <= center_new;
			else if (pkt_en)
				pos_x_q <= next_x;
			if (cfg_wr.height)
				pos_y_q <= center_new;
			else if (pkt_en)
				pos_y_q <= next_y;
		end
	end

endmodule

[design/ps2_mouse_packet_cursor_core.sv]
`timescale 1ns / 1ps

// PS/2 mouse packet decoder with a clamped screen cursor. Feed the bytes
// received from the mouse one transaction at a time on rx_*; they are framed
// by count into 3-byte packets (flags, X, Y) or, with wheel_mode set, 4-byte
// packets (flags, X, Y, Z). Each complete packet yields one result
// transaction on result_*: the cursor moved by the 9-bit X delta (right) and
// the 9-bit Y delta (up on the mouse, so the row decreases), clamped to
// 0..width-1 and 0..height-1, together with the three buttons, the raw flag
// byte and the wheel direction. Bytes that do not finish a packet give no
// result. Throughput is one byte per clock while result_ready stays high: a byte
// sits in the input register, then the add-and-clamp writes the result
// register, so a result is valid once its last byte has passed both registers.
// result_ready low backs up into rx_ready only when both stages are full.
// Registers (APB, word index paddr[3:2]): 0 screen_width, 1 screen_height,
// 2 wheel_mode.
// Writing a size recenters that coordinate; writing wheel_mode restarts
// packet framing. Sizes of 0 act as 1, sizes past 2^COORD_BITS saturate.
// Overflow flag bits are ignored. Write registers only while no byte is in
// flight. Reset: 640 x 480, cursor at 320, 240, three-byte mode.

module ps2_mouse_packet_cursor_core
	import ps2mc_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// byte input
	input  logic                  rx_valid,
	output logic                  rx_ready,
	input  logic [7:0]            rx_byte,
	// result output
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic [COORD_BITS-1:0] cursor_x,
	output logic [COORD_BITS-1:0] cursor_y,
	output logic                  left_button,
	output logic                  right_button,
	output logic                  middle_button,
	output logic [1:0]            wheel_motion,
	output logic [7:0]            raw_flags,
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	cfg_wr_t               cfg_wr;
	logic [COORD_BITS:0]   cfg_wdata;
	logic [COORD_BITS:0]   screen_width_q;
	logic [COORD_BITS:0]   screen_height_q;
	logic                  wheel_mode_q;

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  adv_s1;

	logic                  pkt_done;
	pkt_t                  pkt;
	logic [COORD_BITS-1:0] next_x;
	logic [COORD_BITS-1:0] next_y;
	logic [COORD_BITS-1:0] x_top;
	logic [COORD_BITS-1:0] y_top;

	logic                  result_valid_q;
	logic [COORD_BITS-1:0] cursor_x_q;
	logic [COORD_BITS-1:0] cursor_y_q;
	logic [7:0]            flags_q;
	wheel_t                wheel_q;

	assign pready = 1'b1;

	ps2mc_apb_regs #(
		.COORD_BITS(COORD_BITS)
	) u_regs (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.cfg_wr          (cfg_wr),
		.cfg_wdata       (cfg_wdata),
		.screen_width_q  (screen_width_q),
		.screen_height_q (screen_height_q),
		.wheel_mode_q    (wheel_mode_q)
	);

	// Input register: advance whenever the result slot is free or draining.
	// Bytes that finish no packet advance as well; they only update framing.
	assign adv_s1   = valid_s1 && (!result_valid_q || result_ready);
	assign rx_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready)
			byte_s1 <= rx_byte;
	end

	ps2mc_packet_asm u_asm (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr     (cfg_wr),
		.wheel_mode (wheel_mode_q),
		.byte_en    (adv_s1),
		.rx_byte    (byte_s1),
		.pkt_done   (pkt_done),
		.pkt        (pkt)
	);

	ps2mc_cursor #(
		.COORD_BITS(COORD_BITS)
	) u_cursor (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr        (cfg_wr),
		.cfg_wdata     (cfg_wdata),
		.screen_width  (screen_width_q),
		.screen_height (screen_height_q),
		.pkt_en        (adv_s1 && pkt_done),
		.pkt           (pkt),
		.next_x        (next_x),
		.next_y        (next_y),
		.x_top         (x_top),
		.y_top         (y_top)
	);

	// Result register: load on a finished packet, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv_s1 && pkt_done) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && pkt_done) begin
			cursor_x_q <= next_x;
			cursor_y_q <= next_y;
			flags_q    <= pkt.flags;
			wheel_q    <= pkt.wheel;
		end
	end

	assign result_valid  = result_valid_q;
	assign cursor_x      = cursor_x_q;
	assign cursor_y      = cursor_y_q;
	assign left_button   = flags_q[FLAG_LEFT];
	assign right_button  = flags_q[FLAG_RIGHT];
	assign middle_button = flags_q[FLAG_MIDDLE];
	assign wheel_motion  = wheel_q;
	assign raw_flags     = flags_q;

	// A held result always lies on the screen
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (cursor_x_q <= x_top) && (cursor_y_q <= y_top))
		else $error("cursor result outside the screen");

	// A packet finished in the input stage always shows up as a result
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && pkt_done) |=> result_valid_q)
		else $error("finished packet produced no result");

	// Wheel motion is reported only in four-byte mode
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && pkt_done && !wheel_mode_q) |=> (wheel_q == WHEEL_NONE))
		else $error("wheel motion in three-byte mode");

endmodule

[tb/sv/tb_ps2_mouse_packet_cursor_core.sv]
`timescale 1ns / 1ps

module tb_ps2_mouse_packet_cursor_core;
	import ps2mc_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	// Largest usable screen size; anything written above it saturates here
	localparam int SIZE_CEIL = 1 << CB;
	// Word index with no register behind it; writes there must change nothing
	localparam logic [1:0] REG_UNMAPPED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	// The block holds a byte in its input register and its result register; drain with margin
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_BYTES = 1925;
	localparam int PHASES = 13;
	localparam int PRINT_CAP = 40;

	// One cursor update as the block should report it
	typedef struct {
		logic [CB-1:0] col;
		logic [CB-1:0] row;
		logic          left;
		logic          right;
		logic          middle;
		wheel_t        wheel;
		logic [7:0]    flags;
	} cursor_move_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  rx_valid     = 1'b0;
	logic                  rx_ready;
	logic [7:0]            rx_byte      = 8'h00;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	logic [CB-1:0]         cursor_x;
	logic [CB-1:0]         cursor_y;
	logic                  left_button;
	logic                  right_button;
	logic                  middle_button;
	logic [1:0]            wheel_motion;
	logic [7:0]            raw_flags;
	logic                  psel         = 1'b0;
	logic                  penable      = 1'b0;
	logic                  pwrite       = 1'b0;
	logic [PADDR_BITS-1:0] paddr        = '0;
	logic [31:0]           pwdata       = '0;
	logic [31:0]           prdata;
	logic                  pready;

	// Random idling on each side; both go quiet for the last phase
	bit rx_gaps    = 1'b1;
	bit ready_gaps = 1'b1;
	int ready_hold = 0;

	int mismatch_count = 0;
	int cycle_count    = 0;

	// Mirror of the block's registers and packet framing
	logic [12:0]  scr_width;
	logic [12:0]  scr_height;
	logic         four_byte;
	slot_t        slot;
	logic [7:0]   hold_flags;
	logic [7:0]   hold_dx;
	logic [7:0]   hold_dy;
	int           cur_x;
	int           cur_y;
	cursor_move_t pending_moves[$];

	ps2_mouse_packet_cursor_core #(
		.COORD_BITS(CB)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_valid     (rx_valid),
		.rx_ready     (rx_ready),
		.rx_byte      (rx_byte),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.cursor_x     (cursor_x),
		.cursor_y     (cursor_y),
		.left_button  (left_button),
		.right_button (right_button),
		.middle_button(middle_button),
		.wheel_motion (wheel_motion),
		.raw_flags    (raw_flags),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Cursor predictor
	// ------------------------------------------------------------------

	// Usable size: a zero size acts as one, oversize saturates at the ceiling
	function automatic int size_span(logic [12:0] s);
		if (s == 13'd0)
			return 1;
		if (s > SIZE_CEIL)
			return SIZE_CEIL;
		return int'(s);
	endfunction

	function automatic int clamp_to(int v, logic [12:0] s);
		int top;
		top = size_span(s) - 1;
		if (v < 0)
			return 0;
		if (v > top)
			return top;
		return v;
	endfunction

	// Nine-bit delta: the sign lives in the flag byte, the magnitude in the data byte
	function automatic int delta9(logic [7:0] d, logic neg);
		return neg ? int'(d) - 256 : int'(d);
	endfunction

	function automatic void mouse_reset();
		scr_width  = 13'(SCREEN_WIDTH_DEF);
		scr_height = 13'(SCREEN_HEIGHT_DEF);
		four_byte  = 1'b0;
		slot       = SLOT_FLAGS;
		hold_flags = 8'h00;
		hold_dx    = 8'h00;
		hold_dy    = 8'h00;
		cur_x      = size_span(scr_width) / 2;
		cur_y      = size_span(scr_height) / 2;
	endfunction

	// Size writes recenter their coordinate; a mode write restarts framing
	function automatic void mouse_write_reg(logic [1:0] idx, logic [31:0] d);
		case (idx)
		REG_SCREEN_WIDTH: begin
			scr_width = d[12:0];
			cur_x     = size_span(scr_width) / 2;
		end
		REG_SCREEN_HEIGHT: begin
			scr_height = d[12:0];
			cur_y      = size_span(scr_height) / 2;
		end
		REG_WHEEL_MODE: begin
			four_byte = d[0];
			slot      = SLOT_FLAGS;
		end
		default: ;
		endcase
	endfunction

	// Advance framing by one byte; queue the cursor update when a packet closes
	function automatic void mouse_take_byte(logic [7:0] b);
		cursor_move_t mv;
		slot_t        last;
		last = four_byte ? SLOT_WHEEL : SLOT_DY;
		if (slot < last) begin
			case (slot)
			SLOT_FLAGS: hold_flags = b;
			SLOT_DX:    hold_dx    = b;
			default:    hold_dy    = b;
			endcase
			slot = slot_t'(slot + 2'd1);
			return;
		end
		mv.wheel = WHEEL_NONE;
		if (four_byte) begin
			if (b == WHEEL_DOWN_BYTE)
				mv.wheel = WHEEL_DOWN;
			else if (b == WHEEL_UP_BYTE)
				mv.wheel = WHEEL_UP;
		end else begin
			hold_dy = b;
		end
		slot  = SLOT_FLAGS;
		cur_x = clamp_to(cur_x + delta9(hold_dx, hold_flags[FLAG_XSIGN]), scr_width);
		cur_y = clamp_to(cur_y - delta9(hold_dy, hold_flags[FLAG_YSIGN]), scr_height);
		mv.col    = CB'(cur_x);
		mv.row    = CB'(cur_y);
		mv.left   = hold_flags[FLAG_LEFT];
		mv.right  = hold_flags[FLAG_RIGHT];
		mv.middle = hold_flags[FLAG_MIDDLE];
		mv.flags  = hold_flags;
		pending_moves.push_back(mv);
	endfunction

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------

	task automatic note_mismatch(string what, int got, int want);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
	endtask

	// Compare every result transaction with the oldest pending cursor update
	always @(posedge clk) begin
		cursor_move_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_moves.size() == 0) begin
				note_mismatch("result with nothing pending", 1, 0);
			end else begin
				want = pending_moves.pop_front();
				if (cursor_x !== want.col)
					note_mismatch("cursor_x", cursor_x, want.col);
				if (cursor_y !== want.row)
					note_mismatch("cursor_y", cursor_y, want.row);
				if (left_button !== want.left)
					note_mismatch("left_button", left_button, want.left);
				if (right_button !== want.right)
					note_mismatch("right_button", right_button, want.right);
				if (middle_button !== want.middle)
					note_mismatch("middle_button", middle_button, want.middle);
				if (wheel_motion !== 2'(want.wheel))
					note_mismatch("wheel_motion", wheel_motion, want.wheel);
				if (raw_flags !== want.flags)
					note_mismatch("raw_flags", raw_flags, want.flags);
			end
		end
	end

	// Give up if the run hangs anywhere
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_ps2_mouse_packet_cursor_core failed");
			$finish;
		end
	end

	// Stall the result side in bursts of random length while enabled
	always @(negedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
		end else if (ready_gaps && $urandom_range(0, 5) == 0) begin
			ready_hold = $urandom_range(0, 10);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Drivers; every task starts and ends just after a falling edge
	// ------------------------------------------------------------------

	// Offer one byte, optionally after a gap, and hold it until the transaction
	// completes. Leave valid high so back-to-back bytes need no extra edge.
	task automatic send_byte(logic [7:0] b);
		if (rx_gaps && $urandom_range(0, 3) == 0) begin
			rx_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (!rx_ready)
			@(posedge clk);
		mouse_take_byte(b);
		@(negedge clk);
	endtask

	// Drop valid, wait out every pending result, then let the pipe empty
	task automatic drain();
		rx_valid <= 1'b0;
		while (pending_moves.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Setup phase, access phase, then an idle bus phase
	task automatic write_reg(logic [1:0] idx, logic [31:0] d);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= d;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		mouse_write_reg(idx, d);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_packet(logic [7:0] f, logic [7:0] x, logic [7:0] y);
		send_byte(f);
		send_byte(x);
		send_byte(y);
	endtask

	// Junk in the unused upper bits must not matter
	function automatic logic [31:0] size_word(logic [12:0] s);
		return {19'($urandom()), s};
	endfunction

	function automatic logic [31:0] mode_word(logic m);
		return {31'($urandom()), m};
	endfunction

	// Mostly ordinary sizes, with zero, tiny, full and oversize mixed in
	function automatic logic [12:0] pick_size();
		case ($urandom_range(0, 5))
		0:       return 13'($urandom_range(0, 16));
		1:       return 13'($urandom_range(SIZE_CEIL + 1, 8191));
		2:       return 13'(SIZE_CEIL);
		default: return 13'($urandom_range(1, SIZE_CEIL));
		endcase
	endfunction

	// Shape the next byte by where it lands in the packet
	function automatic logic [7:0] pick_byte();
		logic [7:0] r;
		r = 8'($urandom());
		if (slot == SLOT_WHEEL) begin
			case ($urandom_range(0, 3))
			0:       return WHEEL_DOWN_BYTE;
			1:       return WHEEL_UP_BYTE;
			2:       return 8'h00;
			default: return r;
			endcase
		end
		if (slot != SLOT_FLAGS && $urandom_range(0, 5) == 0) begin
			case ($urandom_range(0, 3))
			0:       return 8'h00;
			1:       return 8'h7F;
			2:       return 8'h80;
			default: return 8'hFF;
			endcase
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Full negative and full positive deltas from the reset center, with every
	// flag bit set once, overflow bits included; both moves hit or leave a clamp.
	task automatic test_motion_extremes();
		send_packet(8'hFF, 8'h00, 8'h00);
		send_packet(8'h0F, 8'hFF, 8'hFF);
		drain();
	endtask

	// Zero sizes act as one, oversize saturates, unmapped writes are dropped
	task automatic test_size_limits();
		write_reg(REG_SCREEN_WIDTH, size_word(13'd0));
		write_reg(REG_SCREEN_HEIGHT, size_word(13'd0));
		send_packet(8'h00, 8'hFF, 8'h00);
		drain();
		write_reg(REG_SCREEN_WIDTH, size_word(13'd8191));
		write_reg(REG_SCREEN_HEIGHT, size_word(13'(SIZE_CEIL + 1)));
		send_packet(8'h30, 8'h80, 8'h80);
		drain();
		write_reg(REG_SCREEN_WIDTH, size_word(13'(SIZE_CEIL)));
		write_reg(REG_SCREEN_HEIGHT, size_word(13'd1));
		write_reg(REG_UNMAPPED, 32'($urandom()));
		send_packet(8'h00, 8'h7F, 8'h01);
		drain();
	endtask

	// Wheel down and up in four-byte mode, then a mode switch mid-packet
	task automatic test_wheel_and_reframe();
		write_reg(REG_SCREEN_WIDTH, size_word(13'(SCREEN_WIDTH_DEF)));
		write_reg(REG_SCREEN_HEIGHT, size_word(13'(SCREEN_HEIGHT_DEF)));
		write_reg(REG_WHEEL_MODE, mode_word(1'b1));
		send_packet(8'h09, 8'h05, 8'h03);
		send_byte(WHEEL_DOWN_BYTE);
		send_packet(8'h3A, 8'hFB, 8'hFD);
		send_byte(WHEEL_UP_BYTE);
		// Leave a packet half done; the mode write must restart framing
		send_byte(8'h1C);
		send_byte(8'h40);
		drain();
		write_reg(REG_WHEEL_MODE, mode_word(1'b0));
		send_packet(8'h0C, 8'h02, 8'h02);
		drain();
	endtask

	// Random phases, each with fresh sizes and mode; idling is picked at random
	// per phase and stays off for the final phase. Phase lengths are a multiple
	// of four bytes but not of three, so a mode write after a three-byte phase lands mid-packet.
	task automatic test_random_traffic();
		bit quiet;
		for (int p = 0; p < PHASES; p++) begin
			quiet      = (p == PHASES - 1);
			rx_gaps    = !quiet && $urandom_range(0, 3) != 0;
			ready_gaps = !quiet && $urandom_range(0, 3) != 0;
			write_reg(REG_SCREEN_WIDTH, size_word(pick_size()));
			write_reg(REG_SCREEN_HEIGHT, size_word(pick_size()));
			write_reg(REG_WHEEL_MODE, mode_word(1'($urandom())));
			repeat (RANDOM_BYTES / PHASES)
				send_byte(pick_byte());
			drain();
		end
	endtask

	initial begin
		mouse_reset();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_motion_extremes();
		test_size_limits();
		test_wheel_and_reframe();
		test_random_traffic();
		if (mismatch_count == 0)
			$display("tb_ps2_mouse_packet_cursor_core passed");
		else
			$display("tb_ps2_mouse_packet_cursor_core failed");
		$finish;
	end

endmodule
